/* src/sgb_pkg.sv */
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared constants, codes and arithmetic helpers of the separable Gaussian blur.
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int RADIUS = 8;
    localparam int TAPS   = 2 * RADIUS + 1;
    localparam int BANK_W = 5;
    localparam int PROD_W = 23;
    localparam int ACC_W  = 24;
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 13;
    localparam int PIX_W  = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'b1;

    // request kinds carried in s_tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [RADIUS:0][PROD_W-1:0] prod_row_t;

    // q0.16 weights for offsets 0 to 8, centre trimmed so the taps sum to 65536
    localparam logic [13:0] GAUSS_W [RADIUS+1] = '{
        14'd8754, 14'd8281, 14'd7009, 14'd5309, 14'd3599,
        14'd2183, 14'd1185, 14'd575,  14'd250
    };

    // product of the weight for offset o with the symmetric pair of samples
    function automatic logic [PROD_W-1:0] tap_prod(input int o, input logic [7:0] a,
                                                   input logic [7:0] b);
        logic [8:0] s;
        if (o == 0) begin
            s = {1'b0, a};
        end else begin
            s = {1'b0, a} + {1'b0, b};
        end
        return PROD_W'(s) * PROD_W'(GAUSS_W[o]);
    endfunction

    // sum of the weighted pairs, truncated to 8 bits after the q0.16 shift
    function automatic logic [7:0] tap_sum(input prod_row_t p);
        logic [ACC_W-1:0] acc;
        acc = '0;
        for (int o = 0; o <= RADIUS; o++) begin
            acc = acc + ACC_W'(p[o]);
        end
        return acc[ACC_W-1 -: 8];
    endfunction

endpackage

/* src/separable_gaussian_blur.sv */
// ----------------------------------------------------------------------------
// separable_gaussian_blur
// 17-tap Gaussian blur (sigma 3) on RGBA raster pixels, rows then columns.
//
// Usage: pixels arrive on the s_ channel in raster order, s_tuser = 0; a
// transfer with s_tuser = 1 is a flush. Results leave on the m_ channel,
// trailing the input by 8 rows and 8 pixels. A pixel transfer gives at most
// one result, except the last pixel of a row, which is followed by 8
// right-edge replication steps that give up to 9 results in total; the
// input is held off during those steps. After the last pixel of a frame
// the block drains the bottom rows, one result per flush transfer, the
// final one flagged in m_tuser; pixels sent while draining are dropped.
// Throughput is one transfer per cycle unless replication or the fifo credit
// check holds the input off, set by the row banks, each taking one write and
// one read a cycle: 17 banks, one per buffered row, read together at one
// column each cycle. Results pass the pipeline registers and then queue in
// an 8-entry output fifo; the input is stalled once queued plus in-flight
// results would overfill it, so a stalled receiver never loses data.
// Reset clears the counters, the fifo and the drain state and loads a
// 1024 x 1024 frame. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
module separable_gaussian_blur #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                        cfg_we,
    input  logic [sgb_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [sgb_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic [0:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red, out_green, out_blue, out_alpha, pixel_col, pixel_row, zero pad
    output logic [((32+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+7)/8)*8-1:0] m_tdata,
    output logic        m_tlast,   // last_in_run
    output logic [0:0]  m_tuser    // frame_done
);
    import sgb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int MDW = ((32 + CW + RW + 7) / 8) * 8;
    localparam int FD  = 8;
    localparam int FAW = $clog2(FD);
    localparam int SW  = $clog2(RADIUS);

    typedef struct packed {
        logic              vld;
        logic              hpass;
        logic              emit;
        logic              last;
        logic              done;
        logic [CW-1:0]     x;
        logic [RW-1:0]     y;
        logic [BANK_W-1:0] ymod;
        logic [BANK_W-1:0] wbank;
    } op_t;

    typedef struct packed {
        logic           done;
        logic           last;
        logic [MDW-1:0] data;
    } fifo_ent_t;

    // configuration
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    // frame position
    logic [CW-1:0]     in_col_reg, in_col_next;
    logic [RW-1:0]     in_row_reg, in_row_next;
    logic [BANK_W-1:0] rmod_reg, rmod_next;
    logic [CW-1:0]     drain_col_reg, drain_col_next;
    logic [RW-1:0]     drain_row_reg, drain_row_next;
    logic [BANK_W-1:0] drain_rmod_reg, drain_rmod_next;
    logic              draining_reg, draining_next;

    // row-end replication sequencer
    logic              seq_busy_reg, seq_busy_next;
    logic [SW-1:0]     seq_cnt_reg, seq_cnt_next;
    logic [CW-1:0]     seq_c_reg;
    logic [RW-1:0]     seq_r_reg;
    logic [BANK_W-1:0] seq_rmod_reg;
    logic              seq_load;
    pixel_t            last_px_reg;

    logic   s_acc, is_flush, can_issue, seq_step;
    op_t    op0;
    logic   win_shift, win_fill;
    pixel_t win_px;
    pixel_t win_reg [TAPS];

    op_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [3:0] inflight;

    prod_row_t [3:0] hprod_next, hprod_reg;
    pixel_t            hres_next, hres_reg;
    logic [BANK_W-1:0] map_next [TAPS];
    logic [BANK_W-1:0] map_reg [TAPS];
    pixel_t            fwd_reg;
    pixel_t            rd_q [TAPS];
    pixel_t            vtap [TAPS];
    prod_row_t [3:0] vprod_next, vprod_reg;
    pixel_t            vres;

    fifo_ent_t       fifo_mem [FD];
    logic [FAW-1:0]  fifo_wp_reg, fifo_rp_reg;
    logic [FAW:0]    fifo_cnt_reg;
    logic            fifo_push, fifo_pop;

    // effective frame size, zero acts as one and oversize is clipped
    always_comb begin
        if (frame_width_reg == '0) begin
            w_last = '0;
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(frame_width_reg - 11'd1);
        end
        if (frame_height_reg == '0) begin
            h_last = '0;
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(frame_height_reg - 13'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 11'd1024;
            frame_height_reg <= 13'd1024;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[10:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // credit check: queued plus in-flight results must fit the fifo
    assign inflight = 4'(s1_reg.vld && s1_reg.emit) + 4'(s2_reg.vld && s2_reg.emit)
                    + 4'(s3_reg.vld && s3_reg.emit) + 4'(s4_reg.vld && s4_reg.emit)
                    + 4'(s5_reg.vld && s5_reg.emit);
    assign can_issue = (5'(fifo_cnt_reg) + 5'(inflight)) < 5'(FD);
    assign s_tready  = !seq_busy_reg && can_issue;
    assign s_acc     = s_tvalid && s_tready;
    assign is_flush  = (s_tuser[0] == REQ_FLUSH);
    assign seq_step  = seq_busy_reg && can_issue;

    // issue stage: turns transfers and replication steps into pipeline ops
    always_comb begin
        logic [CW:0] vc;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        rmod_next       = rmod_reg;
        drain_col_next  = drain_col_reg;
        drain_row_next  = drain_row_reg;
        drain_rmod_next = drain_rmod_reg;
        draining_next   = draining_reg;
        seq_busy_next   = seq_busy_reg;
        seq_cnt_next    = seq_cnt_reg;
        seq_load        = 1'b0;
        op0             = '0;
        win_shift       = 1'b0;
        win_fill        = 1'b0;
        win_px          = s_tdata;
        vc              = '0;
        if (cfg_we) begin
            in_col_next    = '0;
            in_row_next    = '0;
            rmod_next      = '0;
            drain_col_next = '0;
            drain_row_next = '0;
            draining_next  = 1'b0;
        end else if (seq_step) begin
            vc = {1'b0, seq_c_reg} + (CW+1)'(seq_cnt_reg) + (CW+1)'(1);
            win_shift = 1'b1;
            win_px    = last_px_reg;
            op0.hpass = vc >= (CW+1)'(RADIUS);
            op0.emit  = op0.hpass && (seq_r_reg >= RW'(RADIUS));
            op0.last  = op0.emit && (seq_cnt_reg == SW'(RADIUS - 1));
            op0.x     = CW'(vc - (CW+1)'(RADIUS));
            op0.y     = seq_r_reg - RW'(RADIUS);
            op0.ymod  = (seq_rmod_reg >= BANK_W'(RADIUS)) ? seq_rmod_reg - BANK_W'(RADIUS)
                                                          : seq_rmod_reg + BANK_W'(RADIUS+1);
            op0.wbank = seq_rmod_reg;
            op0.vld   = op0.hpass;
            seq_cnt_next = seq_cnt_reg + SW'(1);
            if (seq_cnt_reg == SW'(RADIUS - 1)) begin
                seq_busy_next = 1'b0;
            end
        end else if (s_acc && is_flush) begin
            if (draining_reg) begin
                op0.vld  = 1'b1;
                op0.emit = 1'b1;
                op0.last = 1'b1;
                op0.done = (drain_row_reg == h_last) && (drain_col_reg == w_last);
                op0.x    = drain_col_reg;
                op0.y    = drain_row_reg;
                op0.ymod = drain_rmod_reg;
                if (op0.done) begin
                    in_col_next    = '0;
                    in_row_next    = '0;
                    rmod_next      = '0;
                    drain_col_next = '0;
                    drain_row_next = '0;
                    draining_next  = 1'b0;
                end else if (drain_col_reg == w_last) begin
                    drain_col_next  = '0;
                    drain_row_next  = drain_row_reg + RW'(1);
                    drain_rmod_next = (drain_rmod_reg == BANK_W'(TAPS - 1))
                                      ? '0 : drain_rmod_reg + BANK_W'(1);
                end else begin
                    drain_col_next = drain_col_reg + CW'(1);
                end
            end
        end else if (s_acc && !draining_reg) begin
            win_fill  = (in_col_reg == '0);
            win_shift = 1'b1;
            op0.hpass = in_col_reg >= CW'(RADIUS);
            op0.emit  = op0.hpass && (in_row_reg >= RW'(RADIUS));
            op0.last  = op0.emit && (in_col_reg != w_last);
            op0.x     = in_col_reg - CW'(RADIUS);
            op0.y     = in_row_reg - RW'(RADIUS);
            op0.ymod  = (rmod_reg >= BANK_W'(RADIUS)) ? rmod_reg - BANK_W'(RADIUS)
                                                      : rmod_reg + BANK_W'(RADIUS+1);
            op0.wbank = rmod_reg;
            op0.vld   = op0.hpass;
            if (in_col_reg == w_last) begin
                seq_load      = 1'b1;
                seq_busy_next = 1'b1;
                seq_cnt_next  = '0;
                in_col_next   = '0;
                if (in_row_reg == h_last) begin
                    // bottom of frame: drain starts seven rows up, or at row 0
                    draining_next  = 1'b1;
                    drain_col_next = '0;
                    in_row_next    = '0;
                    rmod_next      = '0;
                    if (in_row_reg >= RW'(RADIUS)) begin
                        drain_row_next  = in_row_reg - RW'(RADIUS - 1);
                        drain_rmod_next = (rmod_reg >= BANK_W'(RADIUS - 1))
                                          ? rmod_reg - BANK_W'(RADIUS - 1)
                                          : rmod_reg + BANK_W'(TAPS - RADIUS + 1);
                    end else begin
                        drain_row_next  = '0;
                        drain_rmod_next = '0;
                    end
                end else begin
                    in_row_next = in_row_reg + RW'(1);
                    rmod_next   = (rmod_reg == BANK_W'(TAPS - 1)) ? '0 : rmod_reg + BANK_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            rmod_reg       <= '0;
            drain_col_reg  <= '0;
            drain_row_reg  <= '0;
            drain_rmod_reg <= '0;
            draining_reg   <= 1'b0;
            seq_busy_reg   <= 1'b0;
            seq_cnt_reg    <= '0;
        end else begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            rmod_reg       <= rmod_next;
            drain_col_reg  <= drain_col_next;
            drain_row_reg  <= drain_row_next;
            drain_rmod_reg <= drain_rmod_next;
            draining_reg   <= draining_next;
            seq_busy_reg   <= seq_busy_next;
            seq_cnt_reg    <= seq_cnt_next;
        end
    end

    // horizontal window: newest pixel at tap 0, row start replicates the first pixel
    always_ff @(posedge aclk) begin
        if (seq_load) begin
            seq_c_reg    <= in_col_reg;
            seq_r_reg    <= in_row_reg;
            seq_rmod_reg <= rmod_reg;
            last_px_reg  <= s_tdata;
        end
        if (win_fill) begin
            for (int i = 0; i < TAPS; i++) begin
                win_reg[i] <= win_px;
            end
        end else if (win_shift) begin
            win_reg[0] <= win_px;
            for (int i = 1; i < TAPS; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
        end else begin
            s1_reg <= op0;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            s5_reg <= s4_reg;
        end
    end

    // horizontal pass: weighted pairs, then the sum
    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            for (int o = 0; o <= RADIUS; o++) begin
                hprod_next[ch][o] = tap_prod(o, win_reg[RADIUS-o][8*ch +: 8],
                                             win_reg[RADIUS+o][8*ch +: 8]);
            end
            hres_next[8*ch +: 8] = tap_sum(hprod_reg[ch]);
        end
    end

    // vertical tap to bank map, clamped at the top and bottom rows
    always_comb begin
        logic [RW-1:0]       dh;
        logic signed [5:0]   offk;
        logic signed [5:0]   bsum;
        dh = h_last - s3_reg.y;
        for (int k = 0; k < TAPS; k++) begin
            offk = 6'(k - RADIUS);
            if (k < RADIUS && s3_reg.y < RW'(RADIUS - k)) begin
                bsum = '0;
            end else begin
                if (k > RADIUS && dh < RW'(k - RADIUS)) begin
                    offk = 6'(dh);
                end
                bsum = $signed({1'b0, s3_reg.ymod}) + offk;
                if (bsum < 0) begin
                    bsum = bsum + 6'sd17;
                end else if (bsum >= 6'sd17) begin
                    bsum = bsum - 6'sd17;
                end
            end
            map_next[k] = BANK_W'(bsum);
        end
    end

    always_ff @(posedge aclk) begin
        hprod_reg <= hprod_next;
        hres_reg  <= hres_next;
        fwd_reg   <= hres_reg;
        map_reg   <= map_next;
        vprod_reg <= vprod_next;
    end

    // one bank per buffered row, all read at the same column
    for (genvar b = 0; b < TAPS; b++) begin : g_bank
        pixel_t mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (s3_reg.vld && s3_reg.hpass && s3_reg.wbank == BANK_W'(b)) begin
                mem[s3_reg.x] <= hres_reg;
            end
            rd_q[b] <= mem[s3_reg.x];
        end
    end

    // the row written in the same cycle as the bank read comes from the forwarded result
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            if (s4_reg.hpass && map_reg[k] == s4_reg.wbank) begin
                vtap[k] = fwd_reg;
            end else begin
                vtap[k] = rd_q[map_reg[k]];
            end
        end
        for (int ch = 0; ch < 4; ch++) begin
            for (int o = 0; o <= RADIUS; o++) begin
                vprod_next[ch][o] = tap_prod(o, vtap[RADIUS-o][8*ch +: 8],
                                             vtap[RADIUS+o][8*ch +: 8]);
            end
            vres[8*ch +: 8] = tap_sum(vprod_reg[ch]);
        end
    end

    // output fifo
    assign fifo_push = s5_reg.vld && s5_reg.emit;
    assign fifo_pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_mem[fifo_wp_reg] <= '{done: s5_reg.done, last: s5_reg.last,
                                       data: MDW'({s5_reg.y, s5_reg.x, vres})};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wp_reg  <= '0;
            fifo_rp_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (fifo_push) begin
                fifo_wp_reg <= fifo_wp_reg + FAW'(1);
            end
            if (fifo_pop) begin
                fifo_rp_reg <= fifo_rp_reg + FAW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + (FAW+1)'(fifo_push) - (FAW+1)'(fifo_pop);
        end
    end

    assign m_tvalid   = (fifo_cnt_reg != '0);
    assign m_tdata    = fifo_mem[fifo_rp_reg].data;
    assign m_tlast    = fifo_mem[fifo_rp_reg].last;
    assign m_tuser[0] = fifo_mem[fifo_rp_reg].done;

endmodule
